/* rtl/swr_pkg.sv */
`default_nettype none

package swr_pkg;

    localparam int MAX_WORD_BITS = 32;
    localparam int BITS_W        = $clog2(MAX_WORD_BITS + 1);
    localparam int WORD_W        = 32;
    localparam int WORD_IDX_W    = $clog2(WORD_W);
    localparam int WORD_BITS_W   = 6;
    localparam int REPEAT_W      = 8;
    localparam int NS_W          = 30;
    localparam int TIMER_W       = 32;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_WORD_BITS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAUSE        = 2'd3;

    localparam logic [WORD_BITS_W-1:0] WORD_BITS_RESET    = 6'd16;
    localparam logic [REPEAT_W-1:0]    REPEAT_COUNT_RESET = 8'd3;
    localparam logic [NS_W-1:0]        HALF_PERIOD_RESET  = 30'd31250;
    localparam logic [NS_W-1:0]        PAUSE_RESET        = 30'd800000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETUP,
        PH_HIGH,
        PH_HOLD,
        PH_PAUSE
    } phase_t;

    typedef struct packed {
        logic [NS_W-1:0]   elapsed_ns;
        logic [WORD_W-1:0] word_in;
        logic              enable_in;
    } tick_t;

    typedef struct packed {
        logic chip_select_n;
        logic serial_clock;
        logic serial_data;
    } pins_t;

endpackage

`default_nettype wire

/* rtl/swr_if.sv */
`default_nettype none

interface swr_tick_if import swr_pkg::*; ();
    logic  valid;
    logic  ready;
    tick_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface swr_pins_if import swr_pkg::*; ();
    logic  valid;
    logic  ready;
    pins_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/spi_word_repeater_tx.sv */
// channel  dir  payload                                     accepted when
// tick     in   elapsed_ns, word_in, enable_in              tick.valid && tick.ready
// pins     out  chip_select_n, serial_clock, serial_data    pins.valid && pins.ready
// cfg      in   cfg_index, cfg_data                         cfg_we
//
// one tick per cycle while the pins output is not stalled; each tick gives one pins item on the next cycle
// the single output register sets the rate: a tick is taken whenever it is
// empty or being drained in the same cycle
// rst_n clears the sequencer and loads the register defaults
// a stalled pins item holds its value and blocks further ticks
`default_nettype none

module spi_word_repeater_tx import swr_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    swr_tick_if.sink                    tick,
    swr_pins_if.source                  pins,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [NS_W-1:0]        cfg_data
);

    logic [WORD_BITS_W-1:0] word_bits_reg;
    logic [REPEAT_W-1:0]    repeat_count_reg;
    logic [NS_W-1:0]        half_period_reg;
    logic [NS_W-1:0]        pause_reg;

    phase_t              phase_reg, phase_next;
    logic [TIMER_W-1:0]  timer_reg, timer_next;
    logic [WORD_W-1:0]   held_word_reg, held_word_next;
    logic [BITS_W-1:0]   bits_left_reg, bits_left_next;
    logic [REPEAT_W-1:0] sends_left_reg, sends_left_next;
    logic                prev_enable_reg, prev_enable_next;
    logic                cs_reg, cs_next;
    logic                sclk_reg, sclk_next;
    logic                sdata_reg, sdata_next;
    logic                out_valid_reg;

    logic                tick_accept;
    logic [TIMER_W:0]    timer_sum;
    logic [TIMER_W-1:0]  timer_sat;
    logic                half_done;
    logic                pause_done;
    logic [BITS_W-1:0]   eff_bits;
    logic [REPEAT_W-1:0] sends_pick;

    function automatic logic word_bit(input logic [WORD_W-1:0] w,
                                      input logic [BITS_W-1:0] idx);
        logic b;
        b = 1'b0;
        if (int'(idx) < WORD_W)
        begin
            b = w[idx[WORD_IDX_W-1:0]];
        end
        return b;
    endfunction

    assign tick.ready  = !out_valid_reg || pins.ready;
    assign tick_accept = tick.valid && tick.ready;

    assign pins.valid              = out_valid_reg;
    assign pins.data.chip_select_n = cs_reg;
    assign pins.data.serial_clock  = sclk_reg;
    assign pins.data.serial_data   = sdata_reg;

    always_comb
    begin
        if (word_bits_reg == '0)
        begin
            eff_bits = BITS_W'(1);
        end
        else if (int'(word_bits_reg) > MAX_WORD_BITS)
        begin
            eff_bits = BITS_W'(MAX_WORD_BITS);
        end
        else
        begin
            eff_bits = BITS_W'(word_bits_reg);
        end
    end

    always_comb
    begin
        // saturating timer
        timer_sum  = {1'b0, timer_reg} + (TIMER_W + 1)'(tick.data.elapsed_ns);
        timer_sat  = timer_sum[TIMER_W] ? '1 : timer_sum[TIMER_W-1:0];
        half_done  = timer_sat >= TIMER_W'(half_period_reg);
        pause_done = timer_sat >= TIMER_W'(pause_reg);

        phase_next       = phase_reg;
        timer_next       = timer_sat;
        held_word_next   = held_word_reg;
        bits_left_next   = bits_left_reg;
        sends_left_next  = sends_left_reg;
        prev_enable_next = prev_enable_reg;
        cs_next          = cs_reg;
        sclk_next        = sclk_reg;
        sdata_next       = sdata_reg;
        sends_pick       = sends_left_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (!tick.data.enable_in)
                begin
                    prev_enable_next = 1'b0;
                end
                else
                begin
                    prev_enable_next = 1'b1;
                    if (!prev_enable_reg)
                    begin
                        sends_pick = repeat_count_reg;
                    end
                    if (tick.data.word_in != held_word_reg && sends_pick == '0)
                    begin
                        sends_pick = repeat_count_reg;
                    end
                    sends_left_next = sends_pick;
                    if (sends_pick != '0)
                    begin
                        held_word_next  = tick.data.word_in;
                        sends_left_next = sends_pick - 1'b1;
                        cs_next         = 1'b0;
                        bits_left_next  = eff_bits - 1'b1;
                        sdata_next      = word_bit(tick.data.word_in, eff_bits - 1'b1);
                        sclk_next       = 1'b0;
                        timer_next      = '0;
                        phase_next      = PH_SETUP;
                    end
                end
            end
            PH_SETUP:
            begin
                if (half_done)
                begin
                    sclk_next  = 1'b1;
                    timer_next = '0;
                    phase_next = PH_HIGH;
                end
            end
            PH_HIGH:
            begin
                if (half_done)
                begin
                    sclk_next  = 1'b0;
                    timer_next = '0;
                    if (bits_left_reg != '0)
                    begin
                        bits_left_next = bits_left_reg - 1'b1;
                        sdata_next     = word_bit(held_word_reg, bits_left_reg - 1'b1);
                        phase_next     = PH_SETUP;
                    end
                    else
                    begin
                        sdata_next = 1'b0;
                        phase_next = PH_HOLD;
                    end
                end
            end
            PH_HOLD:
            begin
                if (half_done)
                begin
                    cs_next    = 1'b1;
                    timer_next = '0;
                    phase_next = PH_PAUSE;
                end
            end
            PH_PAUSE:
            begin
                if (pause_done)
                begin
                    timer_next = '0;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_bits_reg    <= WORD_BITS_RESET;
            repeat_count_reg <= REPEAT_COUNT_RESET;
            half_period_reg  <= HALF_PERIOD_RESET;
            pause_reg        <= PAUSE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WORD_BITS:    word_bits_reg    <= cfg_data[WORD_BITS_W-1:0];
                CFG_REPEAT_COUNT: repeat_count_reg <= cfg_data[REPEAT_W-1:0];
                CFG_HALF_PERIOD:  half_period_reg  <= cfg_data;
                CFG_PAUSE:        pause_reg        <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            timer_reg       <= '0;
            held_word_reg   <= '0;
            bits_left_reg   <= '0;
            sends_left_reg  <= '0;
            prev_enable_reg <= 1'b0;
            cs_reg          <= 1'b1;
            sclk_reg        <= 1'b0;
            sdata_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (tick_accept)
            begin
                phase_reg       <= phase_next;
                timer_reg       <= timer_next;
                held_word_reg   <= held_word_next;
                bits_left_reg   <= bits_left_next;
                sends_left_reg  <= sends_left_next;
                prev_enable_reg <= prev_enable_next;
                cs_reg          <= cs_next;
                sclk_reg        <= sclk_next;
                sdata_reg       <= sdata_next;
                out_valid_reg   <= 1'b1;
            end
            else if (pins.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/swr_checker.sv */
`default_nettype none

module swr_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic tick_valid,
    input wire logic tick_ready,
    input wire logic pins_valid,
    input wire logic pins_ready,
    input wire logic chip_select_n,
    input wire logic serial_clock,
    input wire logic serial_data
);

    // stalled item holds
    a_pins_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pins_valid && !pins_ready |=> pins_valid
            && $stable(chip_select_n) && $stable(serial_clock) && $stable(serial_data))
        else $error("pins item changed while stalled");

    // every tick gives an item next cycle
    a_tick_to_pins: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> pins_valid)
        else $error("tick without pins item");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !pins_valid |-> tick_ready)
        else $error("tick stalled with empty output");

    // clock pulses only inside a frame
    a_sclk_framed: assert property (@(posedge clk) disable iff (!rst_n)
        pins_valid |-> !(serial_clock && chip_select_n))
        else $error("serial clock high while deselected");

    a_sdata_framed: assert property (@(posedge clk) disable iff (!rst_n)
        pins_valid |-> !(serial_data && chip_select_n))
        else $error("serial data high while deselected");

endmodule

bind spi_word_repeater_tx swr_checker u_swr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick_valid    (tick.valid),
    .tick_ready    (tick.ready),
    .pins_valid    (pins.valid),
    .pins_ready    (pins.ready),
    .chip_select_n (pins.data.chip_select_n),
    .serial_clock  (pins.data.serial_clock),
    .serial_data   (pins.data.serial_data)
);

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import swr_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int PHASE_ITEMS = 115;

    class pin_level_tracker;
        logic [WORD_BITS_W-1:0] word_bits;
        logic [REPEAT_W-1:0]    repeat_count;
        logic [NS_W-1:0]        half_period;
        logic [NS_W-1:0]        pause_len;

        phase_t                 phase;
        logic [TIMER_W-1:0]     timer;
        logic [WORD_W-1:0]      held_word;
        logic [5:0]             bits_left;
        logic [REPEAT_W-1:0]    sends_left;
        logic                   prev_enable;
        logic                   cs_level;
        logic                   clk_level;
        logic                   data_level;

        pins_t                  pending_pins[$];
        int unsigned            mismatches;
        int unsigned            ticks_seen;
        int unsigned            frames_started;

        function new();
            word_bits      = WORD_BITS_RESET;
            repeat_count   = REPEAT_COUNT_RESET;
            half_period    = HALF_PERIOD_RESET;
            pause_len      = PAUSE_RESET;
            phase          = PH_IDLE;
            timer          = '0;
            held_word      = '0;
            bits_left      = '0;
            sends_left     = '0;
            prev_enable    = 1'b0;
            cs_level       = 1'b1;
            clk_level      = 1'b0;
            data_level     = 1'b0;
            mismatches     = 0;
            ticks_seen     = 0;
            frames_started = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [NS_W-1:0] value);
            case (idx)
                CFG_WORD_BITS:    word_bits = value[WORD_BITS_W-1:0];
                CFG_REPEAT_COUNT: repeat_count = value[REPEAT_W-1:0];
                CFG_HALF_PERIOD:  half_period = value;
                CFG_PAUSE:        pause_len = value;
                default: ;
            endcase
        endfunction

        function void shift_bit();
            if (bits_left != 0)
                bits_left--;
            data_level = held_word[bits_left[4:0]];
        endfunction

        function void take_tick(tick_t t);
            logic [TIMER_W:0] sum;
            pins_t            want;
            sum = {1'b0, timer} + t.elapsed_ns;
            timer = sum[TIMER_W] ? '1 : sum[TIMER_W-1:0];
            ticks_seen++;
            case (phase)
                PH_IDLE:
                begin
                    if (!t.enable_in)
                        prev_enable = 1'b0;
                    else
                    begin
                        if (!prev_enable)
                        begin
                            prev_enable = 1'b1;
                            sends_left = repeat_count;
                        end
                        if (t.word_in != held_word && sends_left == 0)
                            sends_left = repeat_count;
                        if (sends_left != 0)
                        begin
                            held_word = t.word_in;
                            sends_left--;
                            cs_level = 1'b0;
                            if (word_bits == 0)
                                bits_left = 6'd1;
                            else if (word_bits > MAX_WORD_BITS)
                                bits_left = 6'(MAX_WORD_BITS);
                            else
                                bits_left = word_bits;
                            shift_bit();
                            clk_level = 1'b0;
                            timer = '0;
                            phase = PH_SETUP;
                            frames_started++;
                        end
                    end
                end
                PH_SETUP:
                begin
                    if (timer >= half_period)
                    begin
                        clk_level = 1'b1;
                        timer = '0;
                        phase = PH_HIGH;
                    end
                end
                PH_HIGH:
                begin
                    if (timer >= half_period)
                    begin
                        clk_level = 1'b0;
                        timer = '0;
                        if (bits_left != 0)
                        begin
                            shift_bit();
                            phase = PH_SETUP;
                        end
                        else
                        begin
                            data_level = 1'b0;
                            phase = PH_HOLD;
                        end
                    end
                end
                PH_HOLD:
                begin
                    if (timer >= half_period)
                    begin
                        cs_level = 1'b1;
                        timer = '0;
                        phase = PH_PAUSE;
                    end
                end
                PH_PAUSE:
                begin
                    if (timer >= pause_len)
                    begin
                        timer = '0;
                        phase = PH_IDLE;
                    end
                end
                default: ;
            endcase
            want.chip_select_n = cs_level;
            want.serial_clock  = clk_level;
            want.serial_data   = data_level;
            pending_pins.push_back(want);
        endfunction

        function void check_pins(pins_t got);
            pins_t want;
            if (pending_pins.size() == 0)
            begin
                $error("pins item %b with no tick pending", got);
                mismatches++;
                return;
            end
            want = pending_pins.pop_front();
            if (got.chip_select_n !== want.chip_select_n)
            begin
                $error("chip_select_n expected %b actual %b", want.chip_select_n,
                       got.chip_select_n);
                mismatches++;
            end
            if (got.serial_clock !== want.serial_clock)
            begin
                $error("serial_clock expected %b actual %b", want.serial_clock,
                       got.serial_clock);
                mismatches++;
            end
            if (got.serial_data !== want.serial_data)
            begin
                $error("serial_data expected %b actual %b", want.serial_data,
                       got.serial_data);
                mismatches++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [NS_W-1:0]        cfg_data;

    swr_tick_if tick_ch ();
    swr_pins_if pins_ch ();

    spi_word_repeater_tx uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .pins      (pins_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pin_level_tracker sb;
    int unsigned      quiet_cycles;
    int unsigned      settings_used;
    logic             calm;
    logic [WORD_W-1:0] cur_word;
    logic              cur_enable;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((tick_ch.valid && tick_ch.ready) || (pins_ch.valid && pins_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (tick_ch.valid && tick_ch.ready)
                sb.take_tick(tick_ch.data);
            if (pins_ch.valid && pins_ch.ready)
                sb.check_pins(pins_ch.data);
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
        $display("tb failed");
        $finish;
    end

    // receiver stalls at random in bursts while calm is clear
    initial
    begin
        int unsigned stall;
        stall = 0;
        pins_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall != 0)
            begin
                stall--;
                pins_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall = $urandom_range(0, 18);
                pins_ch.ready <= 1'b0;
            end
            else
                pins_ch.ready <= 1'b1;
        end
    end

    task automatic hold_off(input int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            tick_ch.valid <= 1'b0;
        end
    endtask

    task automatic drive_tick(input logic [NS_W-1:0] elapsed, input logic [WORD_W-1:0] word,
                              input logic enable);
        tick_t t;
        t.elapsed_ns = elapsed;
        t.word_in    = word;
        t.enable_in  = enable;
        @(negedge clk);
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= t;
        do
            @(posedge clk);
        while (!tick_ch.ready);
    endtask

    // sender waits until every pins item is back
    task automatic settle();
        hold_off(1);
        while (sb.pending_pins.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [NS_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.write_reg(idx, value);
    endtask

    task automatic apply_settings(input logic [NS_W-1:0] bits, input logic [NS_W-1:0] reps,
                                  input logic [NS_W-1:0] half, input logic [NS_W-1:0] gap);
        write_reg(CFG_WORD_BITS, bits);
        write_reg(CFG_REPEAT_COUNT, reps);
        write_reg(CFG_HALF_PERIOD, half);
        write_reg(CFG_PAUSE, gap);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned       span;
        logic [NS_W-1:0]   elapsed;
        span = (sb.half_period == 0) ? 50 : sb.half_period;
        repeat (count)
        begin
            if (!calm && $urandom_range(0, 5) == 0)
                hold_off($urandom_range(1, 19));
            case ($urandom_range(0, 15))
                0: cur_word = $urandom;
                1: cur_word = cur_word ^ (32'h1 << $urandom_range(0, 31));
                2: cur_enable = !cur_enable;
                default: ;
            endcase
            if ($urandom_range(0, 9) == 0)
                elapsed = NS_W'($urandom);
            else
                elapsed = NS_W'($urandom_range(0, span));
            drive_tick(elapsed, cur_word, cur_enable);
        end
    endtask

    task automatic run_phase(input logic [NS_W-1:0] bits, input logic [NS_W-1:0] reps,
                             input logic [NS_W-1:0] half, input logic [NS_W-1:0] gap);
        settle();
        apply_settings(bits, reps, half, gap);
        run_random(PHASE_ITEMS);
    endtask

    initial
    begin
        sb            = new();
        settings_used = 1;
        calm          = 1'b0;
        cur_word      = $urandom;
        cur_enable    = 1'b1;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_WORD_BITS;
        cfg_data      = '0;
        tick_ch.valid = 1'b0;
        tick_ch.data  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // timer saturation while idle and disabled
        repeat (5) drive_tick('1, 32'h0, 1'b0);

        // zero word size, zero waits, two repetitions
        settle();
        apply_settings(0, 2, 0, 0);
        drive_tick(0, 32'h8000_0001, 1'b1);
        repeat (4) drive_tick(0, 32'h8000_0001, 1'b1);
        drive_tick(0, 32'h8000_0001, 1'b1);
        repeat (4) drive_tick(0, 32'h8000_0001, 1'b1);
        drive_tick(0, 32'h8000_0001, 1'b1);
        // only an unused high bit changes
        drive_tick(0, 32'h0000_0001, 1'b1);
        // enable drops while busy
        repeat (4) drive_tick('1, 32'hFFFF_FFFF, 1'b0);
        drive_tick(0, 32'h0000_0001, 1'b0);
        drive_tick(0, 32'h0000_0001, 1'b1);

        run_phase(8, 3, 10, 25);
        run_phase(0, 2, 0, 0);
        run_phase(63, 1, 0, 5);
        run_phase(32, 255, 3, 0);
        run_phase(1, 0, 7, 7);
        run_phase(5, 1, 30'h3FFF_FFFF, 30'h3FFF_FFFF);
        run_phase(16, 3, 31250, 800000);
        settle();
        calm = 1'b1;
        apply_settings(12, 4, 2, 3);
        run_random(PHASE_ITEMS);
        settle();

        $display("%0d ticks checked across %0d register settings", sb.ticks_seen,
                 settings_used);
        $display("%0d word transfers started, %0d mismatches", sb.frames_started,
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
